### sv/bfc_pkg.sv
// bfc_pkg: operation and status codes for the buddy free-block store.
// No dependencies.
`default_nettype none

package bfc_pkg;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_MISALIGNED   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE    = 2'd2;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

  localparam int OrderW = 4;
  localparam int AddrW  = 10;

  typedef logic [OrderW-1:0] order_t;
  typedef logic [AddrW-1:0]  addr_t;

endpackage

`default_nettype wire

### sv/buddy_free_coalesce_top.sv
// buddy_free_coalesce_top: buddy-system free bitmap with load, free+merge and query.
// Depends on bfc_pkg. Holds the per-order free bitmap as a one-bit memory.
//
// Usage: after reset the block clears its bitmap, one entry a cycle, all
// 2^(ADDR_BITS+1) entries (2048 at the default) with busy high. A request is
// taken when start is high and busy low. Rejected and unused-op requests
// return their result in the cycle after the request; load, query and a free
// of a block already free pass through S_CHK to the result. Any other free
// climbs one merge level per free buddy, until a buddy is not free or the
// merge reaches the top order: each level clears the buddy, clears the block's own entry and
// reads the next buddy, one bitmap step a cycle. busy falls in the cycle after
// the result. out_valid is high for one cycle per result and cannot be stalled.
`default_nettype none

module buddy_free_coalesce_top #(
  parameter int ADDR_BITS = 10
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          in_op,
  input  wire  bfc_pkg::order_t in_block_order,
  input  wire  bfc_pkg::addr_t  in_block_address,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output bfc_pkg::order_t     out_result_order,
  output bfc_pkg::addr_t      out_result_address,
  output logic                out_is_free
);
  import bfc_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int OW    = $clog2(ADDR_BITS + 1);
  localparam int IW    = ADDR_BITS + 1;
  localparam int XW    = (ADDR_BITS > AddrW) ? ADDR_BITS : AddrW;
  localparam int DEPTH = 1 << IW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_BUD  = 3'd3;
  localparam logic [2:0] S_CLRS = 3'd4;
  localparam logic [2:0] S_LVL  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [1:0]    status_r, status_nxt;
  order_t        res_order_r, res_order_nxt;
  addr_t         res_addr_r, res_addr_nxt;
  logic          is_free_r, is_free_nxt;

  logic          mem [DEPTH];
  logic          rd_data_r;
  logic [IW-1:0] rd_idx;
  logic          we;
  logic [IW-1:0] wa;
  logic          wd;

  logic [XW-1:0] addr_ext;
  logic [XW-1:0] align_mask;
  logic          in_too_large;
  logic          in_misaligned;
  logic [OW-1:0] in_k;
  logic [AW-1:0] in_a;
  logic [AW-1:0] k_bit;
  logic [AW-1:0] buddy_a;
  logic          at_top;

  function automatic logic [IW-1:0] map_idx(input logic [OW-1:0] k,
                                            input logic [AW-1:0] a);
    logic [IW:0] full;
    logic [IW:0] sum;
    begin
      full = (IW+1)'(DEPTH);
      sum  = full - (full >> k) + ((IW+1)'(a) >> k);
      return sum[IW-1:0];
    end
  endfunction

  assign addr_ext      = XW'(in_block_address);
  assign align_mask    = ~({XW{1'b1}} << in_block_order);
  assign in_too_large  = (5'(in_block_order) > 5'(ADDR_BITS)) ||
                         ((addr_ext >> ADDR_BITS) != '0);
  assign in_misaligned = (addr_ext & align_mask) != '0;
  assign in_k          = OW'(in_block_order);
  assign in_a          = AW'(addr_ext);
  assign k_bit         = AW'(1) << k_r;
  assign buddy_a       = a_r ^ k_bit;
  assign at_top        = k_r == OW'(ADDR_BITS);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    status_nxt    = status_r;
    res_order_nxt = res_order_r;
    res_addr_nxt  = res_addr_r;
    is_free_nxt   = is_free_r;
    rd_idx        = map_idx(k_r, a_r);
    we            = 1'b0;
    wa            = map_idx(k_r, a_r);
    wd            = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we          = 1'b1;
        wa          = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_idx = map_idx(in_k, in_a);
        if (start) begin
          op_nxt        = in_op;
          k_nxt         = in_k;
          a_nxt         = in_a;
          res_order_nxt = in_block_order;
          res_addr_nxt  = in_block_address;
          is_free_nxt   = 1'b0;
          status_nxt    = ST_OK;
          priority if (in_op == OP_NONE) begin
            state_nxt = S_DONE;
          end else if (in_too_large) begin
            status_nxt = ST_TOO_LARGE;
            state_nxt  = S_DONE;
          end else if (in_misaligned) begin
            status_nxt = ST_MISALIGNED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        rd_idx    = map_idx(k_r, buddy_a);
        state_nxt = S_DONE;
        priority if (op_r == OP_QUERY) begin
          is_free_nxt = rd_data_r;
        end else if (rd_data_r) begin
          status_nxt = ST_ALREADY_FREE;
        end else if (op_r == OP_LOAD || at_top) begin
          we = 1'b1;
          wd = 1'b1;
        end else begin
          state_nxt = S_BUD;
        end
      end
      S_BUD: begin
        if (rd_data_r) begin
          we        = 1'b1;
          wa        = map_idx(k_r, buddy_a);
          state_nxt = S_CLRS;
        end else begin
          we        = 1'b1;
          wd        = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_CLRS: begin
        we            = 1'b1;
        k_nxt         = k_r + 1'b1;
        a_nxt         = a_r & ~k_bit;
        res_order_nxt = OrderW'({{OrderW{1'b0}}, k_nxt});
        res_addr_nxt  = AddrW'({{AddrW{1'b0}}, a_nxt});
        state_nxt     = S_LVL;
      end
      S_LVL: begin
        rd_idx = map_idx(k_r, buddy_a);
        if (at_top) begin
          we        = 1'b1;
          wd        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BUD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    k_r         <= k_nxt;
    a_r         <= a_nxt;
    status_r    <= status_nxt;
    res_order_r <= res_order_nxt;
    res_addr_r  <= res_addr_nxt;
    is_free_r   <= is_free_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_idx];
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = state_r == S_DONE;
  assign out_status         = status_r;
  assign out_result_order   = res_order_r;
  assign out_result_address = res_addr_r;
  assign out_is_free        = is_free_r;

endmodule

`default_nettype wire

### bench/buddy_free_coalesce_checker.sv
// Checker for the buddy free-block store: watches the request and result ports,
// keeps its own per-order free bitmap, predicts each result and compares it.
// Depends on bfc_pkg for the operation/status codes and field types.
`timescale 1ns / 1ps

module buddy_free_coalesce_checker #(
  parameter int ADDR_BITS = 10
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              busy,
  input  wire  [1:0]       in_op,
  input  bfc_pkg::order_t  in_block_order,
  input  bfc_pkg::addr_t   in_block_address,
  input  wire              out_valid,
  input  wire  [1:0]       out_status,
  input  bfc_pkg::order_t  out_result_order,
  input  bfc_pkg::addr_t   out_result_address,
  input  wire              out_is_free,
  output int               fail_count,
  output int               pending
);
  import bfc_pkg::*;

  localparam int MapDepth = 2 << ADDR_BITS;

  typedef struct packed {
    logic [1:0] status;
    order_t     order;
    addr_t      address;
    logic       is_free;
  } block_result_t;

  logic          free_bits [MapDepth];
  block_result_t awaited_results [$];

  function automatic int unsigned bit_index(int unsigned k, int unsigned a);
    return MapDepth - (MapDepth >> k) + (a >> k);
  endfunction

  // Applies one request to the local bitmap and returns its result.
  function automatic block_result_t apply_request(logic [1:0] op, order_t k_in, addr_t a_in);
    block_result_t r;
    int unsigned   k;
    int unsigned   a;
    int unsigned   buddy;
    k = k_in;
    a = a_in;
    r.status  = ST_OK;
    r.order   = k_in;
    r.address = a_in;
    r.is_free = 1'b0;
    if (op != OP_NONE) begin
      if (k > ADDR_BITS || a >= (1 << ADDR_BITS)) begin
        r.status = ST_TOO_LARGE;
      end else if ((a & ((1 << k) - 1)) != 0) begin
        r.status = ST_MISALIGNED;
      end else if (op == OP_QUERY) begin
        r.is_free = free_bits[bit_index(k, a)];
      end else if (free_bits[bit_index(k, a)]) begin
        r.status = ST_ALREADY_FREE;
      end else begin
        free_bits[bit_index(k, a)] = 1'b1;
        if (op == OP_FREE) begin
          while (k < ADDR_BITS && free_bits[bit_index(k, a ^ (1 << k))]) begin
            buddy = a ^ (1 << k);
            free_bits[bit_index(k, a)] = 1'b0;
            free_bits[bit_index(k, buddy)] = 1'b0;
            a = a & ~(1 << k);
            k = k + 1;
            free_bits[bit_index(k, a)] = 1'b1;
          end
          r.order   = order_t'(k);
          r.address = addr_t'(a);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    block_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      foreach (free_bits[i]) free_bits[i] = 1'b0;
      awaited_results.delete();
      pending <= 0;
    end else begin
      // results of this edge belong to earlier requests, so compare before pushing
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_result_order !== want.order) begin
            $error("result_order: expected %0d, got %0d", want.order, out_result_order);
            errs++;
          end
          if (out_result_address !== want.address) begin
            $error("result_address: expected %0d, got %0d", want.address,
                   out_result_address);
            errs++;
          end
          if (out_is_free !== want.is_free) begin
            $error("is_free: expected %0d, got %0d", want.is_free, out_is_free);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_request(in_op, in_block_order, in_block_address));
      end
      pending <= awaited_results.size();
    end
  end

endmodule

### bench/buddy_free_coalesce_top_tb.sv
// Testbench top for buddy_free_coalesce_top: drives directed and random
// requests with varying sender gaps and gives the verdict.
// Depends on bfc_pkg, the block itself and buddy_free_coalesce_checker.
`timescale 1ns / 1ps

module buddy_free_coalesce_top_tb;
  import bfc_pkg::*;

  localparam int AddrBits      = 10;
  localparam int ItemTarget    = 600;
  localparam int WatchdogLimit = 8000;
  localparam int DrainLimit    = 500;
  localparam int SettleCycles  = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_op = OP_NONE;
  order_t     in_block_order = '0;
  addr_t      in_block_address = '0;

  wire        busy;
  wire        out_valid;
  wire  [1:0] out_status;
  order_t     out_result_order;
  addr_t      out_result_address;
  wire        out_is_free;

  int fail_count;
  int pending;
  int sent = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  int idle_table [3] = '{0, 82, 6};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  buddy_free_coalesce_top #(.ADDR_BITS(AddrBits)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_block_order     (in_block_order),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_order   (out_result_order),
    .out_result_address (out_result_address),
    .out_is_free        (out_is_free)
  );

  buddy_free_coalesce_checker #(.ADDR_BITS(AddrBits)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_block_order     (in_block_order),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_order   (out_result_order),
    .out_result_address (out_result_address),
    .out_is_free        (out_is_free),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("buddy_free_coalesce_top test failed");
      $finish;
    end
  end

  // Holds one request until it is taken; an optional gap goes in front.
  task automatic issue(input logic [1:0] op, input order_t k, input addr_t a);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start            <= 1'b1;
    in_op            <= op;
    in_block_order   <= k;
    in_block_address <= a;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    int         region_order;
    int         sub_order;
    int         count;
    int         base;
    int         i;
    int         j;
    int         t;
    int         slot [8];
    int         noise;
    int         k;
    int         a;
    int         drain;
    logic [1:0] op;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: deep merge chain, repeats, bad blocks, unused op
    issue(OP_QUERY, 4'd0, 10'd0);
    for (i = 0; i < AddrBits; i++) begin
      issue(OP_LOAD, order_t'(i), addr_t'(1 << i));
    end
    issue(OP_FREE, 4'd0, 10'd0);
    issue(OP_QUERY, 4'd10, 10'd0);
    issue(OP_FREE, 4'd10, 10'd0);
    issue(OP_LOAD, 4'd0, 10'd1);
    issue(OP_LOAD, 4'd0, 10'd1);
    issue(OP_FREE, 4'd0, 10'd0);
    issue(OP_LOAD, 4'd3, 10'd5);
    issue(OP_FREE, 4'd3, 10'd5);
    issue(OP_QUERY, 4'd3, 10'd5);
    issue(OP_LOAD, 4'd11, 10'd0);
    issue(OP_FREE, 4'd15, 10'd0);
    issue(OP_QUERY, 4'd12, 10'd1023);
    issue(OP_NONE, 4'd15, 10'd1023);
    issue(OP_NONE, 4'd0, 10'd0);

    while (sent < ItemTarget) begin
      idle_pct = idle_table[(sent / 100) % 3];
      // sweep the sub-blocks of one region in shuffled order so they merge
      region_order = ($urandom_range(9) == 0) ? $urandom_range(6, AddrBits)
                                              : $urandom_range(1, 5);
      sub_order = region_order - $urandom_range(1, (region_order < 3) ? region_order : 3);
      count = 1 << (region_order - sub_order);
      base = ($urandom_range(1023) >> region_order) << region_order;
      for (i = 0; i < count; i++) slot[i] = i;
      for (i = count - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = slot[i];
        slot[i] = slot[j];
        slot[j] = t;
      end
      for (i = 0; i < count; i++) begin
        issue(($urandom_range(99) < 85) ? OP_FREE : OP_LOAD, order_t'(sub_order),
              addr_t'(base + (slot[i] << sub_order)));
      end
      if ($urandom_range(1) == 1) begin
        issue(OP_QUERY, order_t'(region_order), addr_t'(base));
      end
      noise = $urandom_range(0, 3);
      for (i = 0; i < noise; i++) begin
        op = 2'($urandom_range(3));
        k = $urandom_range(15);
        a = $urandom_range(1023);
        if ($urandom_range(1) == 1 && k <= AddrBits) a = (a >> k) << k;
        issue(op, order_t'(k), addr_t'(a));
      end
    end
    start <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("buddy_free_coalesce_top test passed");
    end else begin
      $display("buddy_free_coalesce_top test failed");
    end
    $finish;
  end

endmodule
